FILE: design/tcd_pkg.sv
// Shared types and constants for the TCP connection demultiplexer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tcd_pkg;

   // opcodes carried on req_tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // slot kinds; kind three is kept and behaves as active
   localparam logic [1:0] KIND_FREE   = 2'd0;
   localparam logic [1:0] KIND_LISTEN = 2'd1;

   localparam logic [31:0] BCAST_IP    = {4{8'hff}};
   localparam logic [47:0] BCAST_ETH   = {6{8'hff}};
   localparam logic [16:0] IPHDR_BYTES = 17'd20;

   typedef enum logic [2:0] {
      VERDICT_WRITTEN = 3'd0,
      VERDICT_BCAST   = 3'd1,
      VERDICT_LENGTH  = 3'd2,
      VERDICT_RESET   = 3'd3,
      VERDICT_EXACT   = 3'd4,
      VERDICT_LISTEN  = 3'd5
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] local_ip;
      logic [15:0] local_port;
      logic [31:0] remote_ip;
      logic [15:0] remote_port;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic table_write;
      logic scan_start;
      logic scan_read;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic drop;
      logic scan_last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

FILE: design/tcp_connection_demux_core.sv
// TCP connection demultiplexer top level: controller plus datapath.
// Lookup: the table's single read port is scanned one slot per cycle, and the
// result word is loaded once the scan is done; the next word is taken after the
// result is loaded. Writes and dropped segments skip the scan. A finished word
// may wait while the next is taken. Reset: synchronous, active high; slots free.
`default_nettype none

module tcp_connection_demux_core #(
   parameter int ENTRIES = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // entry_index, entry_kind, source_ip, dest_ip, source_port, dest_port,
   // eth_dest, ip_length, data_offset, zero pad
   input  wire [175:0]  req_tdata,
   // opcode
   input  wire          req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // verdict, match_index, zero pad
   output logic [7:0]   rsp_tdata
);

   tcd_pkg::cmd_type    cmd;
   tcd_pkg::status_type status;

   tcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcd_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: design/tcd_table.sv
// Connection table: one-port-write, one-port-read memory of slot entries.
// Per-slot valid flops make never-written slots read as free. Uses tcd_pkg.
`default_nettype none

module tcd_table #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      wr_en,
   input  wire [IDX_W-1:0]          wr_addr,
   input  tcd_pkg::entry_type       wr_entry,
   input  wire                      rd_en,
   input  wire [IDX_W-1:0]          rd_addr,
   output tcd_pkg::entry_type       rd_entry
);

   tcd_pkg::entry_type mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   tcd_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an unwritten slot reads as free; its tuple fields are then never looked at
   always_comb begin
      rd_entry = rd_data_ff;
      if (!rd_valid_ff) begin
         rd_entry.kind = tcd_pkg::KIND_FREE;
      end
   end

endmodule

`default_nettype wire

FILE: design/tcd_datapath.sv
// Datapath: captures a word, runs the header checks, scans the connection
// table one slot a cycle and holds the result word. Uses tcd_pkg, tcd_table.
`default_nettype none

module tcd_datapath #(
   parameter int ENTRIES = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [175:0]          req_tdata,
   input  wire                  req_tuser,
   input  tcd_pkg::cmd_type     cmd,
   output tcd_pkg::status_type  status,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AW    = (IDX_W > 4) ? IDX_W : 4;

   // captured item
   logic        op_ff;
   logic [3:0]  idx_ff;
   logic [1:0]  kind_ff;
   logic [31:0] sip_ff;
   logic [31:0] dip_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;
   logic [47:0] eth_ff;
   logic [15:0] iplen_ff;
   logic [3:0]  doff_ff;

   logic [IDX_W-1:0] cnt_ff;
   logic             cmp_valid_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             exact_ff;
   logic [IDX_W-1:0] exact_idx_ff;
   logic             partial_ff;
   logic [IDX_W-1:0] part_idx_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_verdict_ff;
   logic [3:0]       rsp_index_ff;
   logic [2:0]       rsp_verdict_in;
   logic [3:0]       rsp_index_in;

   logic             bcast;
   logic             too_short;
   logic [16:0]      min_len;
   logic             in_range;
   logic [AW-1:0]    wr_addr_wide;
   logic [AW-1:0]    hit_wide;
   logic [IDX_W-1:0] hit_idx;
   tcd_pkg::entry_type wr_entry;
   tcd_pkg::entry_type rd_entry;
   logic             listen_hit;
   logic             exact_hit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         idx_ff   <= req_tdata[3:0];
         kind_ff  <= req_tdata[5:4];
         sip_ff   <= req_tdata[37:6];
         dip_ff   <= req_tdata[69:38];
         sport_ff <= req_tdata[85:70];
         dport_ff <= req_tdata[101:86];
         eth_ff   <= req_tdata[149:102];
         iplen_ff <= req_tdata[165:150];
         doff_ff  <= req_tdata[169:166];
      end
   end

   // header checks; broadcast takes precedence over length
   assign bcast     = (eth_ff == tcd_pkg::BCAST_ETH) || (dip_ff == tcd_pkg::BCAST_IP);
   assign min_len   = tcd_pkg::IPHDR_BYTES + {11'd0, doff_ff, 2'b00};
   assign too_short = {1'b0, iplen_ff} < min_len;

   // writes beyond the table change nothing
   assign in_range     = 32'(idx_ff) < ENTRIES;
   assign wr_addr_wide = AW'(idx_ff);

   assign wr_entry.kind        = kind_ff;
   assign wr_entry.local_ip    = dip_ff;
   assign wr_entry.local_port  = dport_ff;
   assign wr_entry.remote_ip   = sip_ff;
   assign wr_entry.remote_port = sport_ff;

   tcd_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd.table_write && in_range),
      .wr_addr  (wr_addr_wide[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (cmd.scan_read),
      .rd_addr  (cnt_ff),
      .rd_entry (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         cnt_ff <= '0;
      end else if (cmd.scan_read) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_read;
      end
      cmp_idx_ff <= cnt_ff;
   end

   // compare stage: one slot per cycle against the captured tuple
   assign listen_hit = (rd_entry.kind == tcd_pkg::KIND_LISTEN)
                       && (dport_ff == rd_entry.local_port)
                       && (((rd_entry.local_ip == '0) && !partial_ff)
                           || (dip_ff == rd_entry.local_ip));
   assign exact_hit  = (rd_entry.kind != tcd_pkg::KIND_FREE)
                       && (rd_entry.kind != tcd_pkg::KIND_LISTEN)
                       && (sip_ff == rd_entry.remote_ip)
                       && (dip_ff == rd_entry.local_ip)
                       && (sport_ff == rd_entry.remote_port)
                       && (dport_ff == rd_entry.local_port);

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         exact_ff   <= 1'b0;
         partial_ff <= 1'b0;
      end else if (cmp_valid_ff) begin
         // keep the first exact hit; later listening hits no longer matter
         if (exact_hit && !exact_ff) begin
            exact_ff     <= 1'b1;
            exact_idx_ff <= cmp_idx_ff;
         end
         if (listen_hit) begin
            partial_ff  <= 1'b1;
            part_idx_ff <= cmp_idx_ff;
         end
      end
   end

   always_comb begin
      hit_idx        = '0;
      rsp_verdict_in = tcd_pkg::VERDICT_RESET;
      if (op_ff == tcd_pkg::OP_WRITE) begin
         rsp_verdict_in = tcd_pkg::VERDICT_WRITTEN;
      end else if (bcast) begin
         rsp_verdict_in = tcd_pkg::VERDICT_BCAST;
      end else if (too_short) begin
         rsp_verdict_in = tcd_pkg::VERDICT_LENGTH;
      end else if (exact_ff) begin
         rsp_verdict_in = tcd_pkg::VERDICT_EXACT;
         hit_idx        = exact_idx_ff;
      end else if (partial_ff) begin
         rsp_verdict_in = tcd_pkg::VERDICT_LISTEN;
         hit_idx        = part_idx_ff;
      end
      hit_wide     = AW'(hit_idx);
      rsp_index_in = hit_wide[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_index_ff   <= rsp_index_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_index_ff, rsp_verdict_ff};

   assign status.is_write  = (op_ff == tcd_pkg::OP_WRITE);
   assign status.drop      = bcast || too_short;
   assign status.scan_last = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result word loaded over one not yet taken");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_write_verdict: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && (op_ff == tcd_pkg::OP_WRITE)) |=>
         (rsp_verdict_ff == tcd_pkg::VERDICT_WRITTEN) && (rsp_index_ff == 4'd0))
      else $error("write item gave a lookup verdict");

   a_nomatch_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_verdict_ff == tcd_pkg::VERDICT_BCAST)
                        || (rsp_verdict_ff == tcd_pkg::VERDICT_LENGTH)
                        || (rsp_verdict_ff == tcd_pkg::VERDICT_RESET)))
         |-> (rsp_index_ff == 4'd0))
      else $error("non-zero slot index without a match");

endmodule

`default_nettype wire

FILE: design/tcd_ctrl.sv
// Controller: sequences capture, header decision, table scan and result load.
// Drives the datapath through tcd_pkg::cmd_type; uses tcd_pkg.
`default_nettype none

module tcd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  tcd_pkg::status_type  status,
   output tcd_pkg::cmd_type     cmd
);

   tcd_pkg::state_type state_ff;
   tcd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tcd_pkg::ST_DECIDE;
            end
         end
         tcd_pkg::ST_DECIDE: begin
            if (status.is_write || status.drop) begin
               state_in = tcd_pkg::ST_FINISH;
            end else begin
               state_in = tcd_pkg::ST_SCAN;
            end
         end
         tcd_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = tcd_pkg::ST_DRAIN;
            end
         end
         tcd_pkg::ST_DRAIN: begin
            state_in = tcd_pkg::ST_FINISH;
         end
         tcd_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = tcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tcd_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         tcd_pkg::ST_DECIDE: begin
            cmd.table_write = status.is_write;
            cmd.scan_start  = !status.is_write && !status.drop;
         end
         tcd_pkg::ST_SCAN: begin
            cmd.scan_read = 1'b1;
         end
         tcd_pkg::ST_FINISH: begin
            // hold until the previous result word has gone
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sim/tcp_connection_demux_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tcp_connection_demux_core: table writes and segment
// lookups go in on the req_ stream, and each verdict word on rsp_ is checked.
// Depends on tcd_pkg and the core RTL.

module tcp_connection_demux_core_tb;

   localparam int SLOTS = 16;
   localparam int RANDOM_WORDS = 1500;
   localparam logic [1:0] KIND_ACTIVE = 2'd2;
   localparam logic [1:0] KIND_THREE  = 2'd3;

   localparam logic [31:0] IP_A = 32'h0a00_0001;
   localparam logic [31:0] IP_B = 32'h0a00_0009;
   localparam logic [31:0] IP_C = 32'hc0a8_0002;
   localparam logic [31:0] IP_D = 32'h0a00_0002;
   localparam logic [47:0] ETH_UNICAST = 48'h0200_0000_0001;

   typedef struct {
      logic        opcode;
      logic [3:0]  entry_index;
      logic [1:0]  entry_kind;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [47:0] eth_dest;
      logic [15:0] ip_length;
      logic [3:0]  data_offset;
   } seg_word_type;

   // Holds its own copy of the connection table and the verdicts still owed.
   class demux_verdict_board;
      logic [1:0]  kind [SLOTS];
      logic [31:0] local_ip [SLOTS];
      logic [15:0] local_port [SLOTS];
      logic [31:0] remote_ip [SLOTS];
      logic [15:0] remote_port [SLOTS];
      tcd_pkg::verdict_type want_verdict [$];
      logic [3:0]  want_slot [$];
      int          errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            kind[i] = tcd_pkg::KIND_FREE;
            local_ip[i] = '0;
            local_port[i] = '0;
            remote_ip[i] = '0;
            remote_port[i] = '0;
         end
         errors = 0;
      endfunction

      function void accept_word(seg_word_type w);
         tcd_pkg::verdict_type v;
         logic [3:0]  hit;
         logic [3:0]  listen_slot;
         bit          have_listen;
         bit          have_exact;
         bit          addr_ok;
         v = tcd_pkg::VERDICT_WRITTEN;
         hit = '0;
         listen_slot = '0;
         have_listen = 1'b0;
         have_exact = 1'b0;
         if (w.opcode == tcd_pkg::OP_WRITE) begin
            if (int'(w.entry_index) < SLOTS) begin
               kind[w.entry_index] = w.entry_kind;
               remote_ip[w.entry_index] = w.source_ip;
               local_ip[w.entry_index] = w.dest_ip;
               remote_port[w.entry_index] = w.source_port;
               local_port[w.entry_index] = w.dest_port;
            end
         end else if (w.eth_dest == tcd_pkg::BCAST_ETH || w.dest_ip == tcd_pkg::BCAST_IP) begin
            v = tcd_pkg::VERDICT_BCAST;
         end else if (int'(w.ip_length) <
                      int'(tcd_pkg::IPHDR_BYTES) + 4 * int'(w.data_offset)) begin
            v = tcd_pkg::VERDICT_LENGTH;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (kind[i] == tcd_pkg::KIND_FREE) begin
                  // skip
               end else if (kind[i] == tcd_pkg::KIND_LISTEN) begin
                  // a wildcard only fills an empty choice; a specific address always wins
                  addr_ok = (local_ip[i] == '0 && !have_listen) || w.dest_ip == local_ip[i];
                  if (addr_ok && w.dest_port == local_port[i]) begin
                     listen_slot = 4'(i);
                     have_listen = 1'b1;
                  end
               end else if (w.source_ip == remote_ip[i] && w.dest_ip == local_ip[i] &&
                            w.source_port == remote_port[i] &&
                            w.dest_port == local_port[i]) begin
                  hit = 4'(i);
                  have_exact = 1'b1;
                  break;
               end
            end
            if (have_exact) begin
               v = tcd_pkg::VERDICT_EXACT;
            end else if (have_listen) begin
               v = tcd_pkg::VERDICT_LISTEN;
               hit = listen_slot;
            end else begin
               v = tcd_pkg::VERDICT_RESET;
            end
         end
         want_verdict.push_back(v);
         want_slot.push_back(hit);
      endfunction

      function void check_verdict(logic [7:0] data);
         tcd_pkg::verdict_type v;
         logic [3:0]  s;
         if (want_verdict.size() == 0) begin
            $error("rsp_tdata: word %h arrived with no verdict pending", data);
            errors++;
         end else begin
            v = want_verdict.pop_front();
            s = want_slot.pop_front();
            if (data[2:0] !== v) begin
               $error("verdict: expected %0d, actual %0d", v, data[2:0]);
               errors++;
            end
            if (data[6:3] !== s) begin
               $error("match_index: expected %0d, actual %0d", s, data[6:3]);
               errors++;
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // what the stimulus believes is in each slot, used to aim lookups at entries
   logic [1:0]  known_kind [SLOTS];
   logic [31:0] known_lip [SLOTS];
   logic [15:0] known_lport [SLOTS];
   logic [31:0] known_rip [SLOTS];
   logic [15:0] known_rport [SLOTS];

   demux_verdict_board board;

   tcp_connection_demux_core #(
      .ENTRIES(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [31:0] pick_ip();
      case ($urandom_range(9))
         0, 1, 2: return IP_A;
         3, 4:    return IP_D;
         5:       return IP_C;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(9))
         0, 1, 2: return 16'd80;
         3, 4:    return 16'd443;
         5:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic seg_word_type mk_write(logic [3:0] idx, logic [1:0] kind,
                                             logic [31:0] sip, logic [31:0] dip,
                                             logic [15:0] sport, logic [15:0] dport);
      seg_word_type w;
      w.opcode = tcd_pkg::OP_WRITE;
      w.entry_index = idx;
      w.entry_kind = kind;
      w.source_ip = sip;
      w.dest_ip = dip;
      w.source_port = sport;
      w.dest_port = dport;
      // ignored by a write, but vary them anyway
      w.eth_dest = {16'($urandom), 32'($urandom)};
      w.ip_length = 16'($urandom);
      w.data_offset = 4'($urandom);
      known_kind[idx] = kind;
      known_rip[idx] = sip;
      known_lip[idx] = dip;
      known_rport[idx] = sport;
      known_lport[idx] = dport;
      return w;
   endfunction

   function automatic seg_word_type mk_lookup(logic [31:0] sip, logic [31:0] dip,
                                              logic [15:0] sport, logic [15:0] dport,
                                              logic [47:0] eth, logic [15:0] len,
                                              logic [3:0] doff);
      seg_word_type w;
      w.opcode = tcd_pkg::OP_LOOKUP;
      w.entry_index = 4'($urandom);
      w.entry_kind = 2'($urandom);
      w.source_ip = sip;
      w.dest_ip = dip;
      w.source_port = sport;
      w.dest_port = dport;
      w.eth_dest = eth;
      w.ip_length = len;
      w.data_offset = doff;
      return w;
   endfunction

   function automatic seg_word_type random_word();
      seg_word_type w;
      logic [1:0]   k;
      int           r;
      int           s;
      int           floor_len;
      if ($urandom_range(99) < 30) begin
         r = $urandom_range(99);
         k = r < 10 ? tcd_pkg::KIND_FREE :
             r < 40 ? tcd_pkg::KIND_LISTEN :
             r < 85 ? KIND_ACTIVE : KIND_THREE;
         return mk_write(4'($urandom_range(SLOTS - 1)), k, pick_ip(),
                         $urandom_range(3) == 0 ? 32'h0 : pick_ip(), pick_port(), pick_port());
      end
      w = mk_lookup(pick_ip(), pick_ip(), pick_port(), pick_port(), '0, '0, '0);
      s = $urandom_range(SLOTS - 1);
      if ($urandom_range(99) < 65 && known_kind[s] != tcd_pkg::KIND_FREE) begin
         // aim at a live slot, now and then with one field knocked off
         w.source_ip = known_rip[s];
         w.dest_ip = known_lip[s];
         w.source_port = known_rport[s];
         w.dest_port = known_lport[s];
         if (known_kind[s] == tcd_pkg::KIND_LISTEN) begin
            w.source_ip = pick_ip();
            w.source_port = pick_port();
            if (known_lip[s] == '0)
               w.dest_ip = pick_ip();
         end
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
               0:       w.source_ip = pick_ip();
               1:       w.dest_ip = pick_ip();
               2:       w.source_port = pick_port();
               default: w.dest_port = pick_port();
            endcase
         end
      end
      w.eth_dest = $urandom_range(19) == 0 ? tcd_pkg::BCAST_ETH
                                            : {16'($urandom), 32'($urandom)};
      if ($urandom_range(24) == 0)
         w.dest_ip = tcd_pkg::BCAST_IP;
      w.data_offset = 4'($urandom);
      floor_len = int'(tcd_pkg::IPHDR_BYTES) + 4 * int'(w.data_offset);
      if ($urandom_range(99) < 8)
         w.ip_length = 16'($urandom_range(floor_len - 1));
      else
         w.ip_length = 16'($urandom_range(65535, floor_len));
      return w;
   endfunction

   task automatic send_word(seg_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = w.opcode;
      req_tdata = {6'b0, w.data_offset, w.ip_length, w.eth_dest, w.dest_port,
                   w.source_port, w.dest_ip, w.source_ip, w.entry_kind, w.entry_index};
      do @(posedge clock); while (!req_tready);
      board.accept_word(w);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_verdict(rsp_tdata);
   end

   initial begin
      seg_word_type directed [$];
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      for (int i = 0; i < SLOTS; i++) begin
         known_kind[i] = tcd_pkg::KIND_FREE;
         known_lip[i] = '0;
         known_lport[i] = '0;
         known_rip[i] = '0;
         known_rport[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table: nothing can match
      directed.push_back(mk_lookup(IP_C, IP_A, 16'hffff, 16'd0, ETH_UNICAST, 16'd1500, 4'd5));
      directed.push_back(mk_write(4'd0, tcd_pkg::KIND_LISTEN, 32'h0, 32'h0, 16'd0, 16'd80));
      directed.push_back(mk_write(4'd3, tcd_pkg::KIND_LISTEN, 32'h0, IP_A, 16'd0, 16'd80));
      directed.push_back(mk_write(4'd5, tcd_pkg::KIND_LISTEN, 32'h0, 32'h0, 16'd0, 16'd80));
      directed.push_back(mk_write(4'd15, KIND_ACTIVE, 32'hffff_ffff, IP_A, 16'hffff, 16'd80));
      directed.push_back(mk_write(4'd7, KIND_THREE, IP_C, IP_D, 16'd1234, 16'd443));
      // specific listener replaces the earlier wildcard
      directed.push_back(mk_lookup(IP_C, IP_A, 16'd5000, 16'd80, ETH_UNICAST, 16'd1500, 4'd5));
      // later wildcard does not replace the first one
      directed.push_back(mk_lookup(IP_C, IP_B, 16'd5000, 16'd80, ETH_UNICAST, 16'd1500, 4'd5));
      directed.push_back(mk_lookup(32'hffff_ffff, IP_A, 16'hffff, 16'd80, ETH_UNICAST,
                                   16'd1500, 4'd5));
      // kind three behaves as active
      directed.push_back(mk_lookup(IP_C, IP_D, 16'd1234, 16'd443, ETH_UNICAST, 16'd1500, 4'd5));
      directed.push_back(mk_write(4'd1, tcd_pkg::KIND_LISTEN, 32'h0, IP_B, 16'd0, 16'd80));
      directed.push_back(mk_lookup(IP_C, IP_B, 16'd5000, 16'd80, ETH_UNICAST, 16'd1500, 4'd5));
      directed.push_back(mk_lookup(IP_C, IP_D, 16'd1234, 16'd443, tcd_pkg::BCAST_ETH,
                                   16'd1500, 4'd5));
      directed.push_back(mk_lookup(IP_C, tcd_pkg::BCAST_IP, 16'd1234, 16'd443, ETH_UNICAST,
                                   16'd1500, 4'd5));
      // broadcast is reported ahead of a short length
      directed.push_back(mk_lookup(IP_C, tcd_pkg::BCAST_IP, 16'd1234, 16'd443,
                                   tcd_pkg::BCAST_ETH, 16'd0, 4'd15));
      directed.push_back(mk_lookup(IP_C, IP_D, 16'd1234, 16'd443, ETH_UNICAST, 16'd0, 4'd15));
      directed.push_back(mk_lookup(IP_C, IP_D, 16'd1234, 16'd443, ETH_UNICAST, 16'd40, 4'd5));
      directed.push_back(mk_lookup(IP_C, IP_D, 16'd1234, 16'd443, ETH_UNICAST, 16'd39, 4'd5));
      // zero destination matches a wildcard slot by equality, so the later one wins
      directed.push_back(mk_lookup(32'h0, 32'h0, 16'd0, 16'd80, 48'h0, 16'hffff, 4'd15));
      directed.push_back(mk_lookup(IP_C, IP_A, 16'd5000, 16'd81, 48'hffff_ffff_fffe,
                                   16'd1500, 4'd5));
      directed.push_back(mk_write(4'd3, tcd_pkg::KIND_FREE, 32'h0, IP_A, 16'd0, 16'd80));
      directed.push_back(mk_lookup(IP_C, IP_A, 16'd5000, 16'd80, ETH_UNICAST, 16'd1500, 4'd5));
      directed.push_back(mk_write(4'd15, KIND_ACTIVE, 32'h0, 32'hffff_fffe, 16'h0, 16'hffff));
      directed.push_back(mk_lookup(32'h0, 32'hffff_fffe, 16'h0, 16'hffff, ETH_UNICAST,
                                   16'd60, 4'd10));
      foreach (directed[i])
         send_word(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 72;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 72;
            end
            default: begin
               send_idle_pct = 28;
               recv_stall_pct = 28;
            end
         endcase
         repeat (RANDOM_WORDS / 4)
            send_word(random_word());
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (board.want_verdict.size() != 0)
         @(posedge clock);
      // catch any stray word after the last verdict
      repeat (SLOTS + 8) @(posedge clock);
      if (board.errors == 0 && board.want_verdict.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
